FILE: sv/cpg_pkg.sv
// Shared types and constants for the circle point generator.
// Used by cpg_front, cpg_queue, cpg_back and circle_point_generator_unit.
// No dependencies.
package cpg_pkg;

    // Fixed field widths.
    localparam int RADIUS_W   = 14;
    localparam int PIXEL_W    = 16;
    localparam int DECISION_W = 18;

    // Depth of the step queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Constants of the midpoint decision rule.
    localparam logic [DECISION_W-1:0] DEC_INIT    = DECISION_W'(3);
    localparam logic [DECISION_W-1:0] DEC_INC_NEG = DECISION_W'(6);
    localparam logic [DECISION_W-1:0] DEC_INC_POS = DECISION_W'(10);

    // Index of the last of the eight symmetric points in one step.
    localparam logic [2:0] LAST_POINT = 3'd7;

    // Command codes of an input beat.
    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_CONT  = 1'b1
    } cmd_t;

    // One octant step handed from front to back.
    typedef struct packed {
        logic signed [PIXEL_W-1:0] cx;
        logic signed [PIXEL_W-1:0] cy;
        logic [RADIUS_W-1:0]       x;
        logic [RADIUS_W-1:0]       y;
        logic                      done;
    } step_t;

endpackage

FILE: sv/cpg_front.sv
// Front end: accepts command beats, keeps the circle walk state and
// produces one step record per emitting beat. Depends on cpg_pkg.
module cpg_front #(
    parameter int COORD_WIDTH = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic signed [COORD_WIDTH-1:0]        center_x,
    input  logic signed [COORD_WIDTH-1:0]        center_y,
    input  logic [cpg_pkg::RADIUS_W-1:0]         radius,
    input  logic                                 q_full,
    output logic                                 push,
    output cpg_pkg::step_t                       push_data
);

    localparam int EXT_W = (COORD_WIDTH > cpg_pkg::PIXEL_W) ? COORD_WIDTH : cpg_pkg::PIXEL_W;

    logic                                   active_reg, active_next;
    logic signed [cpg_pkg::PIXEL_W-1:0]     cx_reg, cx_next;
    logic signed [cpg_pkg::PIXEL_W-1:0]     cy_reg, cy_next;
    logic [cpg_pkg::RADIUS_W-1:0]           x_reg, x_next;
    logic [cpg_pkg::RADIUS_W-1:0]           y_reg, y_next;
    logic [cpg_pkg::DECISION_W-1:0]         p_reg, p_next;

    logic                                   accept;
    logic                                   is_start;
    logic signed [EXT_W-1:0]                cx_ext;
    logic signed [EXT_W-1:0]                cy_ext;
    logic signed [cpg_pkg::PIXEL_W-1:0]     cur_cx;
    logic signed [cpg_pkg::PIXEL_W-1:0]     cur_cy;
    logic [cpg_pkg::RADIUS_W-1:0]           cur_x;
    logic [cpg_pkg::RADIUS_W-1:0]           cur_y;
    logic [cpg_pkg::DECISION_W-1:0]         cur_p;
    logic [cpg_pkg::DECISION_W-1:0]         x4;
    logic [cpg_pkg::DECISION_W-1:0]         y4;
    logic [cpg_pkg::DECISION_W-1:0]         upd_p;
    logic [cpg_pkg::RADIUS_W:0]             upd_x;
    logic signed [cpg_pkg::RADIUS_W:0]      upd_y;
    logic                                   upd_done;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Reduce the center to pixel width; the pixel sums wrap there anyway.
    assign cx_ext = EXT_W'(center_x);
    assign cy_ext = EXT_W'(center_y);

    // Select the walk position: fresh from the beat on start, else the stored one.
    always_comb
    begin
        unique case (cpg_pkg::cmd_t'(cmd))
            cpg_pkg::CMD_START:
            begin
                is_start = 1'b1;
                cur_cx   = cx_ext[cpg_pkg::PIXEL_W-1:0];
                cur_cy   = cy_ext[cpg_pkg::PIXEL_W-1:0];
                cur_x    = '0;
                cur_y    = radius;
                cur_p    = cpg_pkg::DEC_INIT - {3'b000, radius, 1'b0};
            end
            cpg_pkg::CMD_CONT:
            begin
                is_start = 1'b0;
                cur_cx   = cx_reg;
                cur_cy   = cy_reg;
                cur_x    = x_reg;
                cur_y    = y_reg;
                cur_p    = p_reg;
            end
            default:
            begin
                is_start = 1'b0;
                cur_cx   = cx_reg;
                cur_cy   = cy_reg;
                cur_x    = x_reg;
                cur_y    = y_reg;
                cur_p    = p_reg;
            end
        endcase
    end

    // Midpoint decision update: sign of p picks the step.
    assign x4 = {2'b00, cur_x, 2'b00};
    assign y4 = {2'b00, cur_y, 2'b00};

    always_comb
    begin
        upd_x = {1'b0, cur_x} + 15'd1;
        if (cur_p[cpg_pkg::DECISION_W-1])
        begin
            upd_p = cur_p + x4 + cpg_pkg::DEC_INC_NEG;
            upd_y = $signed({1'b0, cur_y});
        end
        else
        begin
            upd_p = cur_p + x4 - y4 + cpg_pkg::DEC_INC_POS;
            upd_y = $signed({1'b0, cur_y}) - 15'sd1;
        end
        upd_done = $signed({1'b0, upd_x}) > $signed({upd_y[cpg_pkg::RADIUS_W], upd_y});
    end

    // A continue beat with no circle in progress is taken and dropped.
    assign push = accept && (is_start || active_reg);

    always_comb
    begin
        push_data.cx   = cur_cx;
        push_data.cy   = cur_cy;
        push_data.x    = cur_x;
        push_data.y    = cur_y;
        push_data.done = upd_done;
    end

    // Next walk state.
    always_comb
    begin
        active_next = active_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        if (push)
        begin
            active_next = !upd_done;
            cx_next     = cur_cx;
            cy_next     = cur_cy;
            x_next      = upd_x[cpg_pkg::RADIUS_W-1:0];
            y_next      = upd_y[cpg_pkg::RADIUS_W-1:0];
            p_next      = upd_p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        p_reg  <= p_next;
    end

endmodule

FILE: sv/cpg_queue.sv
// Two-entry step queue between the front and back ends.
// Depends on cpg_pkg.
module cpg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpg_pkg::step_t  push_data,
    output logic            full,
    output logic            q_valid,
    input  logic            pop,
    output cpg_pkg::step_t  q_data
);

    cpg_pkg::step_t                     entry_reg [cpg_pkg::QUEUE_DEPTH];
    logic [cpg_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cpg_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cpg_pkg::QUEUE_CNT_W-1:0]    count_reg, count_next;

    assign full    = (count_reg == cpg_pkg::QUEUE_CNT_W'(cpg_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + cpg_pkg::QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - cpg_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/cpg_back.sv
// Back end: takes step records from the queue and emits the eight
// symmetric points of each, one beat per cycle while out_ready holds. Depends on cpg_pkg.
module cpg_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  cpg_pkg::step_t                      q_data,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cpg_pkg::PIXEL_W-1:0]  pixel_x,
    output logic signed [cpg_pkg::PIXEL_W-1:0]  pixel_y,
    output logic                                last_of_step,
    output logic                                circle_done
);

    logic                                   busy_reg, busy_next;
    logic [2:0]                             cnt_reg, cnt_next;
    cpg_pkg::step_t                         rec_reg, rec_next;
    logic                                   out_valid_reg, out_valid_next;
    logic signed [cpg_pkg::PIXEL_W-1:0]     px_reg, px_next;
    logic signed [cpg_pkg::PIXEL_W-1:0]     py_reg, py_next;
    logic                                   last_reg, last_next;
    logic                                   done_reg, done_next;

    logic                                   out_load;
    logic                                   step_end;
    logic [cpg_pkg::RADIUS_W-1:0]           off_a;
    logic [cpg_pkg::RADIUS_W-1:0]           off_b;
    logic signed [cpg_pkg::PIXEL_W-1:0]     ext_a;
    logic signed [cpg_pkg::PIXEL_W-1:0]     ext_b;

    // While a step is held, the output register loads whenever it is empty or being drained.
    assign out_load = busy_reg && (!out_valid_reg || out_ready);
    assign step_end = out_load && (cnt_reg == cpg_pkg::LAST_POINT);
    assign pop      = q_valid && (!busy_reg || step_end);

    // Point order: bit 2 swaps x and y, bit 0 negates the x offset,
    // bit 1 negates the y offset.
    always_comb
    begin
        off_a = cnt_reg[2] ? rec_reg.y : rec_reg.x;
        off_b = cnt_reg[2] ? rec_reg.x : rec_reg.y;
        ext_a = $signed({2'b00, off_a});
        ext_b = $signed({2'b00, off_b});
        px_next = cnt_reg[0] ? rec_reg.cx - ext_a : rec_reg.cx + ext_a;
        py_next = cnt_reg[1] ? rec_reg.cy - ext_b : rec_reg.cy + ext_b;
        last_next = (cnt_reg == cpg_pkg::LAST_POINT);
        done_next = rec_reg.done;
    end

    // Sequencer for the eight points of the held step.
    always_comb
    begin
        busy_next = busy_reg;
        if (pop)
        begin
            busy_next = 1'b1;
        end
        else if (step_end)
        begin
            busy_next = 1'b0;
        end
        cnt_next = out_load ? cnt_reg + 3'd1 : cnt_reg;
        rec_next = pop ? q_data : rec_reg;
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (out_load)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

`ifndef ASSERT_OFF
    // The point counter rests at zero between steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 3'd0)
        else $error("point counter not at zero while idle");

    // Finishing a step puts the eighth point, marked last, on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_end |=> out_valid_reg && last_reg)
        else $error("step end did not present the last point");

    // Once a step has started emitting, the output stays occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg != 3'd0) |-> out_valid_reg)
        else $error("output empty in the middle of a step");
`endif

endmodule

FILE: sv/circle_point_generator_unit.sv
// Midpoint circle rasterizer with eight-way symmetry: top level.
// Depends on cpg_pkg, cpg_front, cpg_queue and cpg_back.
// The first point of a step is held in the queue, then the back-end step register, then the output register.
// Throughput: one point per cycle while out_ready holds, set by the back-end sequencer.
// The front takes a new beat while the two-entry queue has room.
// Reset (rst_n, asynchronous) clears the active circle, the queue and the output.
module circle_point_generator_unit #(
    parameter int COORD_WIDTH = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic signed [COORD_WIDTH-1:0]       center_x,
    input  logic signed [COORD_WIDTH-1:0]       center_y,
    input  logic [cpg_pkg::RADIUS_W-1:0]        radius,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cpg_pkg::PIXEL_W-1:0]  pixel_x,
    output logic signed [cpg_pkg::PIXEL_W-1:0]  pixel_y,
    output logic                                last_of_step,
    output logic                                circle_done
);

    logic           q_full;
    logic           q_push;
    cpg_pkg::step_t q_push_data;
    logic           q_valid;
    logic           q_pop;
    cpg_pkg::step_t q_data;

    // Command intake and walk state.
    cpg_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // Step queue.
    cpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (q_pop),
        .q_data    (q_data)
    );

    // Point emission.
    cpg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule

FILE: sim/tb_circle_point_generator_unit.sv
// Testbench for circle_point_generator_unit: a directed table, then random circles.
// Every pixel beat is checked against a midpoint circle predictor kept in this bench, or against its typed table row.
// Depends on cpg_pkg and the circle_point_generator_unit RTL.
module tb_circle_point_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = 15;
    localparam int ITEM_TARGET = 230;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 20;
    localparam int MAX_REPORTS = 10;

    // Idling profiles that the run walks through.
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One expected pixel beat.
    typedef struct packed {
        logic signed [cpg_pkg::PIXEL_W-1:0] px;
        logic signed [cpg_pkg::PIXEL_W-1:0] py;
        logic                               last;
        logic                               done;
    } pixel_t;

    // One row of the directed table. Typed rows carry their expected points
    // directly: n_exp copies of (ex, ey), the last one flagged end of step.
    typedef struct packed {
        cpg_pkg::cmd_t                      op;
        logic signed [CW-1:0]               cx;
        logic signed [CW-1:0]               cy;
        logic [cpg_pkg::RADIUS_W-1:0]       r;
        logic                               typed;
        logic [3:0]                         n_exp;
        logic signed [cpg_pkg::PIXEL_W-1:0] ex;
        logic signed [cpg_pkg::PIXEL_W-1:0] ey;
        logic                               ex_done;
    } stim_row_t;

    localparam int N_DIR = 25;
    localparam stim_row_t DIR_ROWS [N_DIR] = '{
        // Continue straight after reset, then zero radius at several centers.
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 1, 0,      0,      0, 0},
        '{cpg_pkg::CMD_START,      0,      0,     0, 1, 8,      0,      0, 1},
        '{cpg_pkg::CMD_CONT,    1234,  -1234,    77, 1, 0,      0,      0, 0},
        '{cpg_pkg::CMD_START,  16383,  16383,     0, 1, 8,  16383,  16383, 1},
        '{cpg_pkg::CMD_START, -16384, -16384,     0, 1, 8, -16384, -16384, 1},
        '{cpg_pkg::CMD_START,  16383, -16384,     0, 1, 8,  16383, -16384, 1},
        '{cpg_pkg::CMD_START, -16384,  16383,     0, 1, 8, -16384,  16383, 1},
        // Tiny circles, including a continue once the circle is finished.
        '{cpg_pkg::CMD_START,      0,      0,     1, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_START,      5,     -7,     2, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        // Largest radius at the extreme centers, abandoned by a new start.
        '{cpg_pkg::CMD_START,  16383,  16383, 16383, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,  -16384, -16384,     0, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0, 16383, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_START, -16384, -16384, 16383, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        // A whole small circle, walked to its end.
        '{cpg_pkg::CMD_START, -16384,  16383,    10, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0},
        '{cpg_pkg::CMD_CONT,       0,      0,     0, 0, 0,      0,      0, 0}
    };

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                in_valid     = 1'b0;
    logic                                in_ready;
    logic                                cmd          = 1'b0;
    logic signed [CW-1:0]                center_x     = '0;
    logic signed [CW-1:0]                center_y     = '0;
    logic [cpg_pkg::RADIUS_W-1:0]        radius       = '0;
    logic                                out_valid;
    logic                                out_ready    = 1'b0;
    logic signed [cpg_pkg::PIXEL_W-1:0]  pixel_x;
    logic signed [cpg_pkg::PIXEL_W-1:0]  pixel_y;
    logic                                last_of_step;
    logic                                circle_done;

    // Predictor state: the circle walk as the block should hold it.
    logic                                    circ_active = 1'b0;
    int                                      circ_cx     = 0;
    int                                      circ_cy     = 0;
    logic [cpg_pkg::RADIUS_W-1:0]            walk_x      = '0;
    logic [cpg_pkg::RADIUS_W-1:0]            walk_y      = '0;
    logic signed [cpg_pkg::DECISION_W-1:0]   walk_dec    = '0;

    pixel_t                      exp_pixels[$];
    idle_mode_t                  idle_mode   = IDLE_NONE;
    int                          idle_pct;
    int                          stall_pct;
    logic                        hold_req    = 1'b0;
    logic                        hold_taken  = 1'b0;
    int                          hold_left   = 0;
    int                          beats_sent  = 0;
    int                          beats_plotted = 0;
    int                          points_seen = 0;
    int                          circles_done = 0;
    int                          mismatches  = 0;

    circle_point_generator_unit #(
        .COORD_WIDTH (CW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle and stall percentages of the current profile.
    always_comb
    begin
        unique case (idle_mode)
            IDLE_NONE:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                idle_pct  = 77;
                stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                idle_pct  = 0;
                stall_pct = 77;
            end
            IDLE_BOTH:
            begin
                idle_pct  = 35;
                stall_pct = 35;
            end
        endcase
    end

    // Appends one expected pixel beat at the tail of the scoreboard.
    function automatic void queue_pixel(input pixel_t pix);
        exp_pixels.insert(exp_pixels.size(), pix);
    endfunction

    // Applies one beat to the circle walk and returns the points it plots.
    // A start loads the circle; a continue with no circle plots nothing.
    function automatic int plot_step(input cpg_pkg::cmd_t op,
                                     input logic signed [CW-1:0] cx_in,
                                     input logic signed [CW-1:0] cy_in,
                                     input logic [cpg_pkg::RADIUS_W-1:0] r_in,
                                     output pixel_t [7:0] pts);
        int  xs;
        int  ys;
        int  nx;
        int  ny;
        int  p;
        int  a;
        int  b;
        bit  done;
        pts = '0;
        if (op == cpg_pkg::CMD_START)
        begin
            circ_cx     = cx_in;
            circ_cy     = cy_in;
            walk_x      = '0;
            walk_y      = r_in;
            walk_dec    = cpg_pkg::DECISION_W'(3 - 2 * int'(r_in));
            circ_active = 1'b1;
        end
        else if (!circ_active)
            return 0;

        // Sign rule of the decision variable.
        xs = walk_x;
        ys = walk_y;
        p  = walk_dec;
        nx = xs;
        ny = ys;
        if (p < 0)
            p = p + 4 * nx + 6;
        else
        begin
            p  = p + 4 * (nx - ny) + 10;
            ny = ny - 1;
        end
        nx   = nx + 1;
        done = (nx > ny);

        // Eight symmetric points: bit 0 of k negates the x offset, bit 1 the y
        // offset, and the upper half swaps the roles of x and y.
        for (int k = 0; k < 8; k++)
        begin
            a = (k < 4) ? xs : ys;
            b = (k < 4) ? ys : xs;
            pts[k].px   = cpg_pkg::PIXEL_W'(k[0] ? circ_cx - a : circ_cx + a);
            pts[k].py   = cpg_pkg::PIXEL_W'(k[1] ? circ_cy - b : circ_cy + b);
            pts[k].last = (k == 7);
            pts[k].done = done;
        end

        walk_dec = cpg_pkg::DECISION_W'(p);
        walk_x   = cpg_pkg::RADIUS_W'(nx);
        walk_y   = cpg_pkg::RADIUS_W'(ny);
        if (done)
            circ_active = 1'b0;
        return 8;
    endfunction

    // Offers one input beat, waits for it to be taken, then predicts it.
    task automatic send_beat(input cpg_pkg::cmd_t op,
                             input logic signed [CW-1:0] cx_in,
                             input logic signed [CW-1:0] cy_in,
                             input logic [cpg_pkg::RADIUS_W-1:0] r_in,
                             input bit push_model, output int n);
        pixel_t [7:0] pts;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        center_x <= cx_in;
        center_y <= cy_in;
        radius   <= r_in;
        do
            @(posedge clk);
        while (!in_ready);

        n = plot_step(op, cx_in, cy_in, r_in, pts);
        beats_sent++;
        if (n > 0)
            beats_plotted++;
        if (push_model)
            for (int k = 0; k < n; k++)
                queue_pixel(pts[k]);
    endtask

    // Receiver: random stalls per profile, plus one long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Checker: every accepted pixel beat against the oldest expectation.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected pixel beat %0d: (%0d,%0d) last=%0b done=%0b",
                             points_seen, pixel_x, pixel_y, last_of_step, circle_done);
            end
            else
            begin
                want = exp_pixels.pop_front();
                if (pixel_x !== want.px || pixel_y !== want.py ||
                    last_of_step !== want.last || circle_done !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Beat %0d: want (%0d,%0d) l=%0b d=%0b, got (%0d,%0d) l=%0b d=%0b",
                                 points_seen, want.px, want.py, want.last, want.done,
                                 pixel_x, pixel_y, last_of_step, circle_done);
                end
            end
            if (last_of_step === 1'b1 && circle_done === 1'b1)
                circles_done++;
            points_seen++;
        end
    end

    // Stimulus: reset, directed table, random circles, drain, verdict.
    initial
    begin
        int        n;
        int        dir_sent;
        int        rnd_target;
        int        cap;
        int        steps;
        int        kind;
        bit        big;
        logic signed [CW-1:0]          cx;
        logic signed [CW-1:0]          cy;
        logic [cpg_pkg::RADIUS_W-1:0]  r;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table with no idling on either side.
        for (int i = 0; i < N_DIR; i++)
        begin
            send_beat(DIR_ROWS[i].op, DIR_ROWS[i].cx, DIR_ROWS[i].cy, DIR_ROWS[i].r,
                      !DIR_ROWS[i].typed, n);
            if (DIR_ROWS[i].typed)
                for (int k = 0; k < DIR_ROWS[i].n_exp; k++)
                    queue_pixel(pixel_t'{DIR_ROWS[i].ex, DIR_ROWS[i].ey,
                                         (k == 7), DIR_ROWS[i].ex_done});
        end
        dir_sent   = beats_sent;
        rnd_target = ITEM_TARGET - dir_sent;

        // The receiver holds off for a long stretch while beats keep coming.
        hold_req <= 1'b1;

        // Random part: mostly whole circles with random centers, some abandoned
        // by a new start, mixed with stray continues and fully random beats.
        while (beats_sent < ITEM_TARGET)
        begin
            idle_mode <= idle_mode_t'(((beats_sent - dir_sent) * 4) / rnd_target);
            kind = $urandom_range(99);
            if (kind < 75)
            begin
                cx  = CW'($urandom);
                cy  = CW'($urandom);
                big = ($urandom_range(9) == 0);
                r   = big ? cpg_pkg::RADIUS_W'($urandom)
                          : cpg_pkg::RADIUS_W'($urandom_range(40));
                if (big)
                    cap = $urandom_range(1, 6);
                else if ($urandom_range(4) == 0)
                    cap = $urandom_range(0, 4);
                else
                    cap = 100000;
                send_beat(cpg_pkg::CMD_START, cx, cy, r, 1'b1, n);
                steps = 0;
                while (circ_active && steps < cap && beats_sent < ITEM_TARGET)
                begin
                    send_beat(cpg_pkg::CMD_CONT, CW'($urandom), CW'($urandom),
                              cpg_pkg::RADIUS_W'($urandom), 1'b1, n);
                    steps++;
                end
            end
            else if (kind < 88)
                send_beat(cpg_pkg::CMD_CONT, CW'($urandom), CW'($urandom),
                          cpg_pkg::RADIUS_W'($urandom), 1'b1, n);
            else
                send_beat(cpg_pkg::cmd_t'($urandom_range(1)), CW'($urandom), CW'($urandom),
                          ($urandom_range(3) == 0) ? cpg_pkg::RADIUS_W'($urandom)
                                                   : cpg_pkg::RADIUS_W'($urandom_range(20)),
                          1'b1, n);
        end
        in_valid <= 1'b0;

        // Drain everything still expected, then wait out DRAIN_WAIT.
        while (exp_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d input beats, %0d of them plotting points; checked %0d pixel beats.",
                 beats_sent, beats_plotted, points_seen);
        $display("Finished %0d circles over four idling phases and a long hold; %0d mismatches.",
                 circles_done, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #3_000_000;
        $display("Timeout with %0d pixel beats still expected.", exp_pixels.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
